### sv/smd3_pkg.sv
// Shared types and constants of the third-order sliding-mode differentiator.
// Holds number formats, register indexes, operation codes and the
// controller-to-datapath command and status structs. No dependencies.
package smd3_pkg;

   // Number formats
   localparam int DATA_WIDTH  = 48;
   localparam int FRAC_BITS   = 32;
   localparam int GAIN_W      = 32;
   localparam int GAIN_FRAC   = 24;
   localparam int WEIGHT_W    = 40;
   localparam int WEIGHT_FRAC = 40;
   localparam int DB_W        = 32;
   localparam int ACC_W       = 64;
   localparam int PROD_W      = 2 * ACC_W;

   // Square root unit: radicand is the error magnitude shifted up by FRAC_BITS
   localparam int MAG_W      = DATA_WIDTH;
   localparam int ROOT_W     = (MAG_W + FRAC_BITS + 1) / 2;
   localparam int RAD_W      = 2 * ROOT_W;
   localparam int REM_W      = ROOT_W + 3;
   localparam int ROOT_STEPS = ROOT_W;
   localparam int CNT_W      = $clog2(ROOT_STEPS);

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 40;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN0    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN1    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN2    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN3    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT1  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT2  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT3  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_DEADBAND = 3'd7;

   // Multiply program: one operation per product, in summation order
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_P0      = 4'd0;   // r2*r4
   localparam logic [OP_W-1:0] OP_PHI0    = 4'd1;   // corrections
   localparam logic [OP_W-1:0] OP_PHI1    = 4'd2;
   localparam logic [OP_W-1:0] OP_PHI2    = 4'd3;
   localparam logic [OP_W-1:0] OP_PHI3    = 4'd4;
   localparam logic [OP_W-1:0] OP_N0_PHI  = 4'd5;   // z0 update terms
   localparam logic [OP_W-1:0] OP_N0_Z1   = 4'd6;
   localparam logic [OP_W-1:0] OP_N0_Z2   = 4'd7;
   localparam logic [OP_W-1:0] OP_N0_Z3   = 4'd8;
   localparam logic [OP_W-1:0] OP_N1_PHI  = 4'd9;   // z1 update terms
   localparam logic [OP_W-1:0] OP_N1_Z2   = 4'd10;
   localparam logic [OP_W-1:0] OP_N1_Z3   = 4'd11;
   localparam logic [OP_W-1:0] OP_N2_PHI  = 4'd12;  // z2 update terms
   localparam logic [OP_W-1:0] OP_N2_Z3   = 4'd13;
   localparam logic [OP_W-1:0] OP_N3_PHI  = 4'd14;  // z3 update term
   localparam logic [OP_W-1:0] OP_FIRST_W = OP_N0_PHI;
   localparam logic [OP_W-1:0] OP_LAST    = OP_N3_PHI;

   typedef struct packed {
      logic            item_start;  // latch reference, clear flag
      logic            err_calc;    // form error magnitude and sign
      logic            root_init;   // load square root radicand
      logic            root_pass;   // 0: root of |e|, 1: root of r2
      logic            root_step;   // one result bit
      logic            mul_en;      // one partial product
      logic [1:0]      mul_part;
      logic            round_en;    // round, shift and cap product
      logic            wb_en;       // write back the rounded result
      logic [OP_W-1:0] op;
      logic            out_load;    // commit estimates to output
   } cmd_type;

   typedef struct packed {
      logic active;                 // correction applies this item
   } status_type;

endpackage

### sv/smd3_ctrl.sv
// Controller of the differentiator: sequences error, two square roots when
// active, the multiply program and the output transfer. Depends on smd3_pkg.
module smd3_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  smd3_pkg::status_type status,
   output smd3_pkg::cmd_type   cmd
);
   import smd3_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ERR   = 3'd1;
   localparam logic [2:0] S_RINIT = 3'd2;
   localparam logic [2:0] S_ROOT  = 3'd3;
   localparam logic [2:0] S_MUL   = 3'd4;
   localparam logic [2:0] S_RND   = 3'd5;
   localparam logic [2:0] S_WB    = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [2:0]      state_ff, state_in;
   logic            pass_ff, pass_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]      part_ff, part_in;
   logic [OP_W-1:0] op_ff, op_in;
   logic            rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      pass_in      = pass_ff;
      cnt_in       = cnt_ff;
      part_in      = part_ff;
      op_in        = op_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      cmd.op       = op_ff;
      cmd.mul_part = part_ff;
      cmd.root_pass = pass_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.item_start = 1'b1;
               pass_in        = 1'b0;
               state_in       = S_ERR;
            end
         end
         S_ERR: begin
            cmd.err_calc = 1'b1;
            state_in     = S_RINIT;
         end
         S_RINIT: begin
            if (!status.active) begin
               op_in    = OP_FIRST_W;
               part_in  = 2'd0;
               state_in = S_MUL;
            end else begin
               cmd.root_init = 1'b1;
               cnt_in        = '0;
               state_in      = S_ROOT;
            end
         end
         S_ROOT: begin
            cmd.root_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(ROOT_STEPS - 1)) begin
               if (!pass_ff) begin
                  pass_in  = 1'b1;
                  state_in = S_RINIT;
               end else begin
                  op_in    = OP_P0;
                  part_in  = 2'd0;
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            part_in    = part_ff + 1'b1;
            if (part_ff == 2'd3) state_in = S_RND;
         end
         S_RND: begin
            cmd.round_en = 1'b1;
            state_in     = S_WB;
         end
         S_WB: begin
            cmd.wb_en = 1'b1;
            if (op_ff == OP_LAST) begin
               state_in = S_DONE;
            end else begin
               op_in    = op_ff + 1'b1;
               part_in  = 2'd0;
               state_in = S_MUL;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pass_ff      <= 1'b0;
         cnt_ff       <= '0;
         part_ff      <= '0;
         op_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         cnt_ff       <= cnt_in;
         part_ff      <= part_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_accept_to_err: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_ERR))
      else $error("accepted transfer did not start error stage");
   a_root_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROOT) |-> (cnt_ff < CNT_W'(ROOT_STEPS)))
      else $error("root iteration count out of range");
   a_op_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL) |-> (op_ff <= OP_LAST))
      else $error("multiply program index out of range");
   a_hold_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_valid_ff && !rsp_tready) |=> (state_ff == S_DONE))
      else $error("result committed over an untaken result");
`endif

endmodule

### sv/smd3_dp.sv
// Datapath of the differentiator: config registers, estimates, bit-serial
// square root, 32x32 partial-product multiplier, rounding and saturating
// accumulation. Driven by smd3_ctrl commands; depends on smd3_pkg.
module smd3_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [smd3_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [smd3_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic signed [smd3_pkg::DATA_WIDTH-1:0] ref_in,
   input  smd3_pkg::cmd_type             cmd,
   output smd3_pkg::status_type          status,
   output logic signed [smd3_pkg::DATA_WIDTH-1:0] z0_out,
   output logic signed [smd3_pkg::DATA_WIDTH-1:0] z1_out,
   output logic signed [smd3_pkg::DATA_WIDTH-1:0] z2_out,
   output logic signed [smd3_pkg::DATA_WIDTH-1:0] z3_out,
   output logic                          sat_out
);
   import smd3_pkg::*;

   localparam logic signed [ACC_W-1:0] S64_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] S64_MIN = ~S64_MAX;
   localparam logic signed [ACC_W-1:0] DW_MAX =
      {{(ACC_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] DW_MIN = ~DW_MAX;
   localparam logic [ACC_W-1:0] ONE_Q = ACC_W'(1) << FRAC_BITS;

   // configuration registers
   logic [GAIN_W-1:0]   gain_ff [4];
   logic [WEIGHT_W-1:0] w1_ff, w2_ff, w3_ff;
   logic [DB_W-1:0]     db_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff[0] <= GAIN_W'(42694123);
         gain_ff[1] <= GAIN_W'(77037054);
         gain_ff[2] <= GAIN_W'(72740975);
         gain_ff[3] <= GAIN_W'(30198989);
         w1_ff      <= WEIGHT_W'(64'd4398046511);
         w2_ff      <= WEIGHT_W'(8796093);
         w3_ff      <= WEIGHT_W'(11728);
         db_ff      <= DB_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GAIN0:    gain_ff[0] <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN1:    gain_ff[1] <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN2:    gain_ff[2] <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN3:    gain_ff[3] <= csr_wdata[GAIN_W-1:0];
            CSR_WEIGHT1:  w1_ff      <= csr_wdata[WEIGHT_W-1:0];
            CSR_WEIGHT2:  w2_ff      <= csr_wdata[WEIGHT_W-1:0];
            CSR_WEIGHT3:  w3_ff      <= csr_wdata[WEIGHT_W-1:0];
            CSR_DEADBAND: db_ff      <= csr_wdata[DB_W-1:0];
            default: ;
         endcase
      end
   end

   // estimates, reference and per-item state
   logic signed [DATA_WIDTH-1:0] z_ff [4];
   logic signed [DATA_WIDTH-1:0] n_ff [4];
   logic signed [DATA_WIDTH-1:0] ref_ff;
   logic [MAG_W-1:0]  mag_ff;
   logic              pos_ff, active_ff, flag_ff, sat_ff;
   logic [ROOT_W-1:0] r2_ff, root_ff;
   logic [RAD_W-1:0]  rad_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [ACC_W-1:0]  p0_ff, res_ff;
   logic signed [ACC_W-1:0] phi_ff [4];
   logic signed [ACC_W-1:0] acc_ff;
   logic [PROD_W-1:0] prod_ff;

   assign status.active = active_ff;
   assign z0_out = z_ff[0];
   assign z1_out = z_ff[1];
   assign z2_out = z_ff[2];
   assign z3_out = z_ff[3];
   assign sat_out = sat_ff;

   // error magnitude
   logic signed [DATA_WIDTH:0] diff;
   logic [DATA_WIDTH:0]        diff_mag;
   assign diff     = {z_ff[0][DATA_WIDTH-1], z_ff[0]} - {ref_ff[DATA_WIDTH-1], ref_ff};
   assign diff_mag = diff[DATA_WIDTH] ? 0 - diff : diff;

   // square root step
   logic [REM_W-1:0] rem_sh, trial;
   assign rem_sh = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
   assign trial  = REM_W'({root_ff, 2'b01});

   // operand selection per program op
   function automatic logic [ACC_W-1:0] absz(input logic signed [DATA_WIDTH-1:0] v);
      logic [DATA_WIDTH-1:0] m;
      m = v[DATA_WIDTH-1] ? 0 - v : v;
      return ACC_W'(m);
   endfunction

   function automatic logic [ACC_W-1:0] absp(input logic signed [ACC_W-1:0] v);
      return v[ACC_W-1] ? 0 - v : v;
   endfunction

   logic [ACC_W-1:0] op_a, op_b;
   logic             op_neg;
   logic [1:0]       grp;
   logic             grp_first, grp_last;
   logic [1:0]       sh_sel;   // 0: FRAC_BITS, 1: GAIN_FRAC, 2: WEIGHT_FRAC

   always_comb begin
      op_a = '0; op_b = '0; op_neg = 1'b0; grp = 2'd0;
      grp_first = 1'b0; grp_last = 1'b0; sh_sel = 2'd2;
      unique case (cmd.op)
         OP_P0:     begin op_a = ACC_W'(r2_ff); op_b = ACC_W'(root_ff); sh_sel = 2'd0; end
         OP_PHI0:   begin op_a = ACC_W'(gain_ff[0]); op_b = p0_ff;
                          op_neg = pos_ff; sh_sel = 2'd1; end
         OP_PHI1:   begin op_a = ACC_W'(gain_ff[1]); op_b = ACC_W'(r2_ff);
                          op_neg = pos_ff; sh_sel = 2'd1; end
         OP_PHI2:   begin op_a = ACC_W'(gain_ff[2]); op_b = ACC_W'(root_ff);
                          op_neg = pos_ff; sh_sel = 2'd1; end
         OP_PHI3:   begin op_a = ACC_W'(gain_ff[3]); op_b = ONE_Q;
                          op_neg = pos_ff; sh_sel = 2'd1; end
         OP_N0_PHI: begin op_a = ACC_W'(w1_ff); op_b = absp(phi_ff[0]);
                          op_neg = phi_ff[0][ACC_W-1]; grp = 2'd0; grp_first = 1'b1; end
         OP_N0_Z1:  begin op_a = ACC_W'(w1_ff); op_b = absz(z_ff[1]);
                          op_neg = z_ff[1][DATA_WIDTH-1]; grp = 2'd0; end
         OP_N0_Z2:  begin op_a = ACC_W'(w2_ff); op_b = absz(z_ff[2]);
                          op_neg = z_ff[2][DATA_WIDTH-1]; grp = 2'd0; end
         OP_N0_Z3:  begin op_a = ACC_W'(w3_ff); op_b = absz(z_ff[3]);
                          op_neg = z_ff[3][DATA_WIDTH-1]; grp = 2'd0; grp_last = 1'b1; end
         OP_N1_PHI: begin op_a = ACC_W'(w1_ff); op_b = absp(phi_ff[1]);
                          op_neg = phi_ff[1][ACC_W-1]; grp = 2'd1; grp_first = 1'b1; end
         OP_N1_Z2:  begin op_a = ACC_W'(w1_ff); op_b = absz(z_ff[2]);
                          op_neg = z_ff[2][DATA_WIDTH-1]; grp = 2'd1; end
         OP_N1_Z3:  begin op_a = ACC_W'(w2_ff); op_b = absz(z_ff[3]);
                          op_neg = z_ff[3][DATA_WIDTH-1]; grp = 2'd1; grp_last = 1'b1; end
         OP_N2_PHI: begin op_a = ACC_W'(w1_ff); op_b = absp(phi_ff[2]);
                          op_neg = phi_ff[2][ACC_W-1]; grp = 2'd2; grp_first = 1'b1; end
         OP_N2_Z3:  begin op_a = ACC_W'(w1_ff); op_b = absz(z_ff[3]);
                          op_neg = z_ff[3][DATA_WIDTH-1]; grp = 2'd2; grp_last = 1'b1; end
         OP_N3_PHI: begin op_a = ACC_W'(w1_ff); op_b = absp(phi_ff[3]);
                          op_neg = phi_ff[3][ACC_W-1]; grp = 2'd3;
                          grp_first = 1'b1; grp_last = 1'b1; end
         default: ;
      endcase
   end

   // one 32x32 partial product per cycle while mul_en is set
   logic [31:0]       a_half, b_half;
   logic [ACC_W-1:0]  pp;
   logic [PROD_W-1:0] pp_sh;
   assign a_half = cmd.mul_part[1] ? op_a[63:32] : op_a[31:0];
   assign b_half = cmd.mul_part[0] ? op_b[63:32] : op_b[31:0];
   assign pp     = ACC_W'(a_half) * ACC_W'(b_half);

   always_comb begin
      case (cmd.mul_part)
         2'd0:    pp_sh = PROD_W'(pp);
         2'd3:    pp_sh = PROD_W'(pp) << 64;
         default: pp_sh = PROD_W'(pp) << 32;
      endcase
   end

   // round half up on magnitude, shift, cap at signed 64-bit max
   logic [PROD_W:0] rnd_s, rnd_q;
   always_comb begin
      case (sh_sel)
         2'd0: begin
            rnd_s = {1'b0, prod_ff} + ((PROD_W+1)'(1) << (FRAC_BITS - 1));
            rnd_q = rnd_s >> FRAC_BITS;
         end
         2'd1: begin
            rnd_s = {1'b0, prod_ff} + ((PROD_W+1)'(1) << (GAIN_FRAC - 1));
            rnd_q = rnd_s >> GAIN_FRAC;
         end
         default: begin
            rnd_s = {1'b0, prod_ff} + ((PROD_W+1)'(1) << (WEIGHT_FRAC - 1));
            rnd_q = rnd_s >> WEIGHT_FRAC;
         end
      endcase
   end
   logic rnd_cap;
   assign rnd_cap = |rnd_q[PROD_W:ACC_W-1];

   // signed term and saturating accumulation
   logic signed [ACC_W-1:0] wb_val, acc_sat, acc_cl;
   logic signed [ACC_W:0]   acc_sum;
   logic                    acc_ovf, acc_clip;
   always_comb begin
      wb_val   = op_neg ? 0 - res_ff : res_ff;
      acc_sum  = {acc_ff[ACC_W-1], acc_ff} + {wb_val[ACC_W-1], wb_val};
      acc_ovf  = acc_sum[ACC_W] != acc_sum[ACC_W-1];
      acc_sat  = acc_ovf ? (acc_sum[ACC_W] ? S64_MIN : S64_MAX) : acc_sum[ACC_W-1:0];
      acc_clip = (acc_sat > DW_MAX) || (acc_sat < DW_MIN);
      acc_cl   = (acc_sat > DW_MAX) ? DW_MAX : ((acc_sat < DW_MIN) ? DW_MIN : acc_sat);
   end

   // control-free payload registers
   always_ff @(posedge clock) begin
      if (cmd.item_start) ref_ff <= ref_in;

      if (cmd.err_calc) begin
         mag_ff    <= diff_mag[MAG_W-1:0];
         pos_ff    <= !diff[DATA_WIDTH] && (diff != 0);
         active_ff <= (diff != 0) && (diff_mag[MAG_W-1:0] >= MAG_W'(db_ff));
         for (int i = 0; i < 4; i++) phi_ff[i] <= '0;
      end

      // square root
      if (cmd.root_init) begin
         rem_ff  <= '0;
         root_ff <= '0;
         if (cmd.root_pass) begin
            r2_ff  <= root_ff;
            rad_ff <= RAD_W'({root_ff, {FRAC_BITS{1'b0}}});
         end else begin
            rad_ff <= RAD_W'({mag_ff, {FRAC_BITS{1'b0}}});
         end
      end else if (cmd.root_step) begin
         rad_ff <= rad_ff << 2;
         if (rem_sh >= trial) begin
            rem_ff  <= rem_sh - trial;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end

      // multiplier
      if (cmd.mul_en) begin
         prod_ff <= (cmd.mul_part == 2'd0) ? pp_sh : prod_ff + pp_sh;
         if (cmd.mul_part == 2'd0 && grp_first) acc_ff <= ACC_W'(z_ff[grp]);
      end
      if (cmd.round_en) res_ff <= rnd_cap ? S64_MAX : rnd_q[ACC_W-1:0];

      // write back
      if (cmd.wb_en) begin
         unique case (cmd.op)
            OP_P0:   p0_ff     <= res_ff;
            OP_PHI0: phi_ff[0] <= wb_val;
            OP_PHI1: phi_ff[1] <= wb_val;
            OP_PHI2: phi_ff[2] <= wb_val;
            OP_PHI3: phi_ff[3] <= wb_val;
            default: begin
               if (grp_last) n_ff[grp] <= acc_cl[DATA_WIDTH-1:0];
               else          acc_ff    <= acc_sat;
            end
         endcase
      end
   end

   // saturation flag and estimates
   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff <= 1'b0;
         sat_ff  <= 1'b0;
         for (int i = 0; i < 4; i++) z_ff[i] <= '0;
      end else begin
         if (cmd.item_start) flag_ff <= 1'b0;
         else if (cmd.round_en && rnd_cap) flag_ff <= 1'b1;
         else if (cmd.wb_en && cmd.op >= OP_FIRST_W &&
                  (acc_ovf || (grp_last && acc_clip))) flag_ff <= 1'b1;
         if (cmd.out_load) begin
            sat_ff <= flag_ff;
            for (int i = 0; i < 4; i++) z_ff[i] <= n_ff[i];
         end
      end
   end

endmodule

### sv/sliding_mode_differentiator_order3.sv
// Third-order sliding-mode differentiator, top level.
// Inside the deadband an item runs the error setup, 10 products and the output
// load; outside it two square roots and five more products are added. One item
// in flight: a new request is taken only after the result is loaded, and an
// untaken result stalls the next load.
// Synchronous active-high reset restores register defaults and zero estimates.
module sliding_mode_differentiator_order3 (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,   // [47:0] reference
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [191:0] rsp_tdata,   // estimate_value, _first, _second, _third
   output logic [0:0]   rsp_tuser,   // [0] saturated
   input  logic         csr_we,
   input  logic [smd3_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [smd3_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import smd3_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic signed [DATA_WIDTH-1:0] z0, z1, z2, z3;
   logic sat;

   smd3_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   smd3_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .ref_in    (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .z0_out    (z0),
      .z1_out    (z1),
      .z2_out    (z2),
      .z3_out    (z3),
      .sat_out   (sat)
   );

   assign rsp_tdata = {z3, z2, z1, z0};
   assign rsp_tuser = sat;

endmodule
